[rtl/octave_value_noise_generator_assert.svh]
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef OCTAVE_VALUE_NOISE_GENERATOR_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_GENERATOR_ASSERT_SVH

// clocked property, disabled while reset is high
`define OVNG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define OVNG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ovng_pkg.sv]
// shared types, constants and the interpolation weight table
// no dependencies
package ovng_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int INDEX_BITS  = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int HEIGHT_BITS = 24;
   localparam int AMP_BITS    = 16;
   localparam int OCTAVE_BITS = 4;
   localparam int MAX_OCTAVES = INDEX_BITS + 1;
   localparam int QUOT_BITS   = 17;
   localparam int WEIGHT_BITS = 17;
   localparam int ROM_LEN     = 256;
   localparam int OUT_BITS    = 16;
   localparam int CSR_BITS    = 16;

   localparam logic [1:0] MODE_WRITE    = 2'd0;
   localparam logic [1:0] MODE_GENERATE = 2'd1;
   localparam logic [1:0] MODE_READ     = 2'd2;

   localparam logic CSR_OCTAVE_COUNT = 1'b0;
   localparam logic CSR_PERSISTENCE  = 1'b1;

   localparam logic [OCTAVE_BITS-1:0] OCTAVE_COUNT_RESET = 4'd8;
   localparam logic [AMP_BITS-1:0]    PERSISTENCE_RESET  = 16'd16384;
   localparam logic [AMP_BITS-1:0]    AMP_ONE            = 16'd32768;

   typedef struct packed {
      logic [1:0]             mode;
      logic [INDEX_BITS-1:0]  table_index;
      logic [SAMPLE_BITS-1:0] sample_value;
   } ovng_req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] height_value;
      logic                status;
   } ovng_rsp_type;

   typedef logic [WEIGHT_BITS-1:0] weight_rom_type [ROM_LEN];

   // g[p] = round(65536 * sin^2(pi*p/512)) via a q30 taylor series
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] sq;
      for (int p = 0; p < ROM_LEN; p++) begin
         x = (64'(p) * 64'd1686629713) >> 8;
         term = x;
         sum = x;
         for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         if (sum > (64'd1 << 30)) begin
            sum = 64'd1 << 30;
         end
         sq = (sum * sum + (64'd1 << 43)) >> 44;
         rom[p] = WEIGHT_BITS'(sq);
      end
      return rom;
   endfunction

endpackage

[rtl/ovng_ram.sv]
// single-port-write, single-port-read memory with registered read data
// no dependencies
module ovng_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ovng_divider.sv]
// restoring divider for the normalize pass, one quotient bit per cycle
// depends on ovng_pkg
module ovng_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ovng_pkg::HEIGHT_BITS-1:0] dividend,
   input  logic [ovng_pkg::HEIGHT_BITS-1:0] divisor,
   output logic                            done,
   output logic [ovng_pkg::QUOT_BITS-1:0]   quotient
);
   import ovng_pkg::*;

   localparam int CNT_BITS = $clog2(QUOT_BITS);

   logic [HEIGHT_BITS:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [HEIGHT_BITS:0]   trial;
   logic                   fits;

   // first step compares without a shift: the dividend never exceeds the divisor
   always_comb begin
      trial = (cnt_ff == '0) ? rem_ff : {rem_ff[HEIGHT_BITS-1:0], 1'b0};
      fits = trial >= {1'b0, divisor};
   end

   always_comb begin
      rem_in = rem_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, dividend};
         quot_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial - {1'b0, divisor} : trial;
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/octave_value_noise_generator.sv]
// top level: command decode, octave sequencer and normalize pass
// depends on ovng_pkg, ovng_ram, ovng_divider and the assertion header
//
// One-dimensional octave value noise over a 256-entry wrap-around table.
// A beat is taken when start is high and busy is low; every beat gives
// exactly one result on rsp_data, marked by rsp_strobe for one cycle, and
// the receiver has to take it then. A write-sample beat (mode 0) and a
// mode 3 beat answer in the cycle after they are taken, a read-height beat
// (mode 2) after a registered height memory read and a response state.
// A generate beat (mode 1) walks the table once per octave, each entry
// taking two noise memory reads on its single read port, scale, mix and
// accumulate, with an amplitude update after each octave, then one normalize
// sweep whose entries are each set by the 17-step divider, or a zero sweep
// over all 256 entries when the map is flat. Octaves default to 8. The flat
// status reads zero until the first generate; heights are valid only after it.
// Configuration may be written only while busy is low and no result is due.
module octave_value_noise_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ovng_pkg::ovng_req_type req_data,
   output logic                 rsp_strobe,
   output ovng_pkg::ovng_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [ovng_pkg::CSR_BITS-1:0] csr_write_data
);
   import ovng_pkg::*;

   `include "octave_value_noise_generator_assert.svh"

   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(65536);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_SAT = '1;

   typedef enum logic [12:0] {
      ST_IDLE       = 13'b0000000000001,
      ST_READ_RSP   = 13'b0000000000010,
      ST_GEN_RD_A   = 13'b0000000000100,
      ST_GEN_RD_B   = 13'b0000000001000,
      ST_GEN_SCALE  = 13'b0000000010000,
      ST_GEN_MIX    = 13'b0000000100000,
      ST_GEN_ACC    = 13'b0000001000000,
      ST_GEN_AMP    = 13'b0000010000000,
      ST_NORM_RD    = 13'b0000100000000,
      ST_NORM_START = 13'b0001000000000,
      ST_NORM_DIV   = 13'b0010000000000,
      ST_FLAT_WR    = 13'b0100000000000,
      ST_DONE       = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [OCTAVE_BITS-1:0] octave_count_ff;
   logic [AMP_BITS-1:0]    persistence_ff;

   // sequencer
   logic [OCTAVE_BITS-1:0] eff_ff, eff_in;
   logic [OCTAVE_BITS-1:0] k_ff, k_in;
   logic [INDEX_BITS-1:0]  i_ff, i_in;
   logic [AMP_BITS-1:0]    amp_ff, amp_in;
   logic [HEIGHT_BITS-1:0] min_ff, min_in;
   logic [HEIGHT_BITS-1:0] max_ff, max_in;
   logic                   flat_map_ff, flat_map_in;

   // datapath registers
   logic [WEIGHT_BITS-1:0] g_ff, g_in;
   logic [SAMPLE_BITS-1:0] na_ff, na_in;
   logic [SAMPLE_BITS:0]   y0_ff, y0_in, y1_ff, y1_in;
   logic [34:0]            p0_ff, p0_in, p1_ff, p1_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   ovng_rsp_type           rsp_data_ff, rsp_data_in;

   // memories
   logic                   nw_en, nr_en;
   logic [INDEX_BITS-1:0]  nr_addr;
   logic [SAMPLE_BITS-1:0] nr_data;
   logic                   hw_en, hr_en;
   logic [INDEX_BITS-1:0]  hw_addr, hr_addr;
   logic [HEIGHT_BITS-1:0] hw_data, hr_data;

   // divider
   logic                   div_start, div_done;
   logic [QUOT_BITS-1:0]   div_quot;

   // lattice addressing for octave k
   logic [INDEX_BITS:0]    lattice_step;
   logic [INDEX_BITS-1:0]  offset_mask, lat_a, lat_b, phase;

   // arithmetic
   logic [31:0]            scale_a, scale_b;
   logic [32:0]            amp_prod;
   logic [34:0]            mix_sum;
   logic [18:0]            mix_v;
   logic [HEIGHT_BITS-1:0] acc_base, acc_sat;
   logic [HEIGHT_BITS:0]   acc_sum;
   logic [17:0]            amp_next;
   logic                   last_octave;
   logic                   accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      lattice_step = (INDEX_BITS + 1)'(TABLE_SIZE) >> k_ff;
      offset_mask = INDEX_BITS'(lattice_step - 1'b1);
      lat_a = i_ff & ~offset_mask;
      lat_b = lat_a + INDEX_BITS'(lattice_step);
      phase = i_ff << k_ff;
   end

   // scaled samples, then interpolation products, then accumulate
   // 16x16 product plus rounding stays below 2^32
   always_comb begin
      scale_a = 32'(na_ff) * 32'(amp_ff) + 32'd16384;
      scale_b = 32'(nr_data) * 32'(amp_ff) + 32'd16384;
      mix_sum = p0_ff + p1_ff + 35'd32768;
      mix_v = mix_sum[34:16];
      acc_base = (k_ff == '0) ? '0 : hr_data;
      acc_sum = {1'b0, acc_base} + (HEIGHT_BITS + 1)'(mix_v);
      acc_sat = acc_sum[HEIGHT_BITS] ? HEIGHT_SAT : acc_sum[HEIGHT_BITS-1:0];
      amp_prod = 33'(amp_ff) * 33'(persistence_ff) + 33'd16384;
      amp_next = amp_prod[32:15];
      last_octave = (k_ff == eff_ff - 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      eff_in = eff_ff;
      k_in = k_ff;
      i_in = i_ff;
      amp_in = amp_ff;
      min_in = min_ff;
      max_in = max_ff;
      flat_map_in = flat_map_ff;
      g_in = g_ff;
      na_in = na_ff;
      y0_in = y0_ff;
      y1_in = y1_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      nw_en = 1'b0;
      nr_en = 1'b0;
      nr_addr = lat_a;
      hw_en = 1'b0;
      hw_addr = i_ff;
      hw_data = acc_sat;
      hr_en = 1'b0;
      hr_addr = i_ff;
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            hr_addr = req_data.table_index;
            if (accept) begin
               if (req_data.mode == MODE_WRITE) begin
                  nw_en = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_data_in = '{height_value: '0, status: flat_map_ff};
               end else if (req_data.mode == MODE_GENERATE) begin
                  eff_in = (octave_count_ff > OCTAVE_BITS'(MAX_OCTAVES)) ?
                           OCTAVE_BITS'(MAX_OCTAVES) : octave_count_ff;
                  k_in = '0;
                  i_in = '0;
                  amp_in = AMP_ONE;
                  if (octave_count_ff == '0) begin
                     // nothing summed: all heights zero, map flat
                     min_in = '0;
                     max_in = '0;
                     flat_map_in = 1'b1;
                     state_in = ST_FLAT_WR;
                  end else begin
                     min_in = '1;
                     max_in = '0;
                     state_in = ST_GEN_RD_A;
                  end
               end else if (req_data.mode == MODE_READ) begin
                  hr_en = 1'b1;
                  state_in = ST_READ_RSP;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in = '{height_value: '0, status: flat_map_ff};
               end
            end
         end
         ST_READ_RSP: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in = '{height_value: hr_data[OUT_BITS-1:0], status: flat_map_ff};
            state_in = ST_IDLE;
         end
         ST_GEN_RD_A: begin
            nr_en = 1'b1;
            nr_addr = lat_a;
            hr_en = 1'b1;
            g_in = WEIGHT_ROM[phase];
            state_in = ST_GEN_RD_B;
         end
         ST_GEN_RD_B: begin
            nr_en = 1'b1;
            nr_addr = lat_b;
            na_in = nr_data;
            state_in = ST_GEN_SCALE;
         end
         ST_GEN_SCALE: begin
            y0_in = scale_a[31:15];
            y1_in = scale_b[31:15];
            state_in = ST_GEN_MIX;
         end
         ST_GEN_MIX: begin
            p0_in = 35'(y0_ff) * 35'(WEIGHT_ONE - g_ff);
            p1_in = 35'(y1_ff) * 35'(g_ff);
            state_in = ST_GEN_ACC;
         end
         ST_GEN_ACC: begin
            hw_en = 1'b1;
            // final octave sees the finished heights: track the range here
            if (last_octave) begin
               if (acc_sat < min_ff) begin
                  min_in = acc_sat;
               end
               if (acc_sat > max_ff) begin
                  max_in = acc_sat;
               end
            end
            i_in = i_ff + 1'b1;
            state_in = (i_ff == '1) ? ST_GEN_AMP : ST_GEN_RD_A;
         end
         ST_GEN_AMP: begin
            amp_in = (amp_next > 18'(16'hFFFF)) ? '1 : amp_next[AMP_BITS-1:0];
            k_in = k_ff + 1'b1;
            if (last_octave) begin
               if (min_ff == max_ff) begin
                  flat_map_in = 1'b1;
                  state_in = ST_FLAT_WR;
               end else begin
                  flat_map_in = 1'b0;
                  state_in = ST_NORM_RD;
               end
            end else begin
               state_in = ST_GEN_RD_A;
            end
         end
         ST_NORM_RD: begin
            hr_en = 1'b1;
            state_in = ST_NORM_START;
         end
         ST_NORM_START: begin
            div_start = 1'b1;
            state_in = ST_NORM_DIV;
         end
         ST_NORM_DIV: begin
            if (div_done) begin
               hw_en = 1'b1;
               hw_data = div_quot[QUOT_BITS-1] ? HEIGHT_BITS'(16'hFFFF) :
                         HEIGHT_BITS'(div_quot[QUOT_BITS-2:0]);
               i_in = i_ff + 1'b1;
               state_in = (i_ff == '1) ? ST_DONE : ST_NORM_RD;
            end
         end
         ST_FLAT_WR: begin
            hw_en = 1'b1;
            hw_data = '0;
            i_in = i_ff + 1'b1;
            if (i_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in = '{height_value: '0, status: flat_map_ff};
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         octave_count_ff <= OCTAVE_COUNT_RESET;
         persistence_ff <= PERSISTENCE_RESET;
         min_ff <= '1;
         max_ff <= '0;
         amp_ff <= AMP_ONE;
         flat_map_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         eff_ff <= '0;
         k_ff <= '0;
         i_ff <= '0;
      end else begin
         state_ff <= state_in;
         min_ff <= min_in;
         max_ff <= max_in;
         amp_ff <= amp_in;
         flat_map_ff <= flat_map_in;
         rsp_strobe_ff <= rsp_strobe_in;
         eff_ff <= eff_in;
         k_ff <= k_in;
         i_ff <= i_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_OCTAVE_COUNT: octave_count_ff <= csr_write_data[OCTAVE_BITS-1:0];
               CSR_PERSISTENCE:  persistence_ff <= csr_write_data[AMP_BITS-1:0];
               default: ;
            endcase
         end
      end
      g_ff <= g_in;
      na_ff <= na_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   ovng_ram #(
      .ADDR_BITS(INDEX_BITS),
      .DATA_BITS(SAMPLE_BITS)
   ) u_noise_ram (
      .clock  (clock),
      .wr_en  (nw_en),
      .wr_addr(req_data.table_index),
      .wr_data(req_data.sample_value),
      .rd_en  (nr_en),
      .rd_addr(nr_addr),
      .rd_data(nr_data)
   );

   ovng_ram #(
      .ADDR_BITS(INDEX_BITS),
      .DATA_BITS(HEIGHT_BITS)
   ) u_height_ram (
      .clock  (clock),
      .wr_en  (hw_en),
      .wr_addr(hw_addr),
      .wr_data(hw_data),
      .rd_en  (hr_en),
      .rd_addr(hr_addr),
      .rd_data(hr_data)
   );

   ovng_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(hr_data - min_ff),
      .divisor (max_ff - min_ff),
      .done    (div_done),
      .quotient(div_quot)
   );

   `OVNG_ASSERT(a_done_answers, clock, reset, state_ff == ST_DONE |=> rsp_strobe, "generate gave no result")
   `OVNG_ASSERT(a_div_in_norm, clock, reset, div_done |-> state_ff == ST_NORM_DIV, "divider finished outside normalize")
   `OVNG_ASSERT(a_span_open, clock, reset, state_ff == ST_NORM_START |-> min_ff < max_ff, "normalize with empty span")
   `OVNG_ASSERT(a_flat_span, clock, reset, state_ff == ST_FLAT_WR |-> min_ff == max_ff, "flat sweep with open span")
   `OVNG_ASSERT_ALWAYS(a_height_wr, clock, hw_en |-> (state_ff == ST_GEN_ACC || state_ff == ST_NORM_DIV || state_ff == ST_FLAT_WR), "height write outside generate")

endmodule
